>>> src/aes_ks_pkg.sv
// shared constants, types and lookup functions of the aes-128 key schedule
package aes_ks_pkg;

  localparam int unsigned WORDS = 44;
  localparam logic [5:0] LAST_INDEX = 6'(WORDS - 1);
  localparam logic [5:0] KEY_WORDS = 6'd4;

  // control handed to the word unit for one step
  typedef struct packed {
    logic       rot_sub;   // rotate, substitute and add round constant
    logic [3:0] rcon_idx;
  } ks_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // round constant in the top byte; indices past the tenth give no xor
  function automatic logic [31:0] rcon(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'h0100_0000;
      4'd1:    r = 32'h0200_0000;
      4'd2:    r = 32'h0400_0000;
      4'd3:    r = 32'h0800_0000;
      4'd4:    r = 32'h1000_0000;
      4'd5:    r = 32'h2000_0000;
      4'd6:    r = 32'h4000_0000;
      4'd7:    r = 32'h8000_0000;
      4'd8:    r = 32'h1b00_0000;
      4'd9:    r = 32'h3600_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

>>> src/aes_ks_word_unit.sv
// shared step unit: derives one schedule word from the previous word and the word four back
module aes_ks_word_unit (
  input  logic               [31:0] prev,
  input  logic               [31:0] back,
  input  aes_ks_pkg::ks_ctl_t       ctl,
  output logic               [31:0] word
);
  import aes_ks_pkg::*;

  logic [31:0] rot;
  logic [31:0] sub;

  assign rot = {prev[23:0], prev[31:24]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      sub[b*8 +: 8] = SBOX[rot[b*8 +: 8]];
    end
  end

  assign word = ctl.rot_sub ? (back ^ sub ^ rcon(ctl.rcon_idx)) : (back ^ prev);

endmodule

>>> src/aes128_key_schedule.sv
// top level of the aes-128 key schedule generator
//
// accepts one 128-bit key as two 64-bit halves and streams out the 44 words of
// the aes-128 key expansion, one word per handshake, each with its index and a
// last mark on word 43. words 0 to 3 are the key split little-endian (low half
// of key_first_half first). the sequencer derives one word per step through the
// single shared word unit and loads it into the output register at every edge
// where that register is free or being emptied. when the output side never
// stalls, words leave one per cycle; each stalled output cycle holds the run
// back. in_ready is low from the accepted key until its last word is loaded
// into the output register, so a new key can be taken in the cycle after that.
module aes128_key_schedule (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] key_first_half,
  input  logic [63:0] key_second_half,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  word_index,
  output logic [31:0] schedule_word,
  output logic        last_word
);
  import aes_ks_pkg::*;

  // sequencer state
  logic       busy;
  logic [5:0] word_counter;
  logic [3:0] round_constant_index;

  // key latched at accept, and the last four words (0 oldest, 3 newest)
  logic [127:0] key;
  logic [31:0]  word_window [4];

  logic        advance;
  logic        in_fire;
  logic [31:0] key_word;
  logic [31:0] unit_word;
  logic [31:0] new_word;
  ks_ctl_t     ctl;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  // step whenever a word is due and the output register is free or emptying
  assign advance = busy && (!out_valid || out_ready);

  // first four words come straight from the key
  always_comb begin
    case (word_counter[1:0])
      2'd0:    key_word = key[31:0];
      2'd1:    key_word = key[63:32];
      2'd2:    key_word = key[95:64];
      default: key_word = key[127:96];
    endcase
  end

  assign ctl.rot_sub  = (word_counter[1:0] == 2'd0);
  assign ctl.rcon_idx = round_constant_index;

  aes_ks_word_unit u_word_unit (
    .prev (word_window[3]),
    .back (word_window[0]),
    .ctl  (ctl),
    .word (unit_word)
  );

  assign new_word = (word_counter < KEY_WORDS) ? key_word : unit_word;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy                 <= 1'b0;
      word_counter         <= '0;
      round_constant_index <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (in_fire) begin
        busy                 <= 1'b1;
        word_counter         <= '0;
        round_constant_index <= '0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        if (word_counter == LAST_INDEX) begin
          // run done, back to idle
          busy                 <= 1'b0;
          word_counter         <= '0;
          round_constant_index <= '0;
        end else begin
          word_counter <= word_counter + 6'd1;
          // round constant moves on after each rotate-and-substitute word
          if (ctl.rot_sub && (word_counter >= KEY_WORDS)) begin
            round_constant_index <= round_constant_index + 4'd1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key <= {key_second_half, key_first_half};
    end
    if (advance) begin
      word_window[0] <= word_window[1];
      word_window[1] <= word_window[2];
      word_window[2] <= word_window[3];
      word_window[3] <= new_word;
      word_index     <= word_counter;
      schedule_word  <= new_word;
      last_word      <= (word_counter == LAST_INDEX);
    end
  end

endmodule
